FILE: hdl/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
// Used by the pattern store, closure and top-level modules; depends on nothing.
`timescale 1ns / 1ps

package wgm_pkg;

    // Default pattern capacity in bytes
    localparam int PATTERN_LEN_DEF = 32;

    // Wildcard bytes
    localparam logic [7:0] STAR_BYTE  = 8'd42;
    localparam logic [7:0] QMARK_BYTE = 8'd63;

    // Input word commands
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Pattern update request from the top level
    typedef struct packed {
        logic       clear;
        logic       append;
        logic [7:0] char_value;
    } t_pat_ctrl;

endpackage

FILE: hdl/wgm_pattern.sv
// Pattern store: bytes, length, used-position mask and the restart set.
// Also decodes each stored byte against the current text byte.
// Depends on wgm_pkg.
`timescale 1ns / 1ps

module wgm_pattern #(
    parameter int PATTERN_LEN = wgm_pkg::PATTERN_LEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  wgm_pkg::t_pat_ctrl                 i_ctrl,
    input  logic [7:0]                         i_text,
    output logic [$clog2(PATTERN_LEN+1)-1:0]   o_count,
    output logic [$clog2(PATTERN_LEN+1)-1:0]   o_count_next,
    output logic [PATTERN_LEN:0]               o_start_next,
    output logic                               o_full,
    output logic [PATTERN_LEN-1:0]             o_star,
    output logic [PATTERN_LEN-1:0]             o_hit
);

    localparam int CW = $clog2(PATTERN_LEN + 1);
    localparam int IW = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [PATTERN_LEN-1:0] r_used;
    logic [PATTERN_LEN-1:0] n_used;
    logic [PATTERN_LEN:0]   r_start;
    logic [PATTERN_LEN:0]   n_start;
    logic [7:0]             r_store [PATTERN_LEN];
    logic                   full;
    logic                   do_write;
    logic                   new_star;

    assign full     = (r_count == CW'(PATTERN_LEN));
    assign do_write = i_ctrl.append & ~full;
    assign new_star = (i_ctrl.char_value == wgm_pkg::STAR_BYTE);

    // Work out length, mask and restart set after a clear or append
    always_comb begin
        n_count = r_count;
        n_used  = r_used;
        n_start = r_start;
        if (i_ctrl.clear) begin
            n_count = '0;
            n_used  = '0;
            n_start = {{PATTERN_LEN{1'b0}}, 1'b1};
        end else if (do_write) begin
            n_count = r_count + CW'(1);
            for (int j = 0; j < PATTERN_LEN; j++) begin
                if (r_count == CW'(j)) begin
                    n_used[j]    = 1'b1;
                    // a star reached from the start extends the start run
                    n_start[j+1] = r_start[j+1] | (r_start[j] & new_star);
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_used  <= '0;
            r_start <= {{PATTERN_LEN{1'b0}}, 1'b1};
        end else begin
            r_count <= n_count;
            r_used  <= n_used;
            r_start <= n_start;
        end
    end

    // Write the appended byte at the current length
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_store[r_count[IW-1:0]] <= i_ctrl.char_value;
        end
    end

    // Decode every stored byte against the text byte
    always_comb begin
        for (int i = 0; i < PATTERN_LEN; i++) begin
            o_star[i] = r_used[i] & (r_store[i] == wgm_pkg::STAR_BYTE);
            o_hit[i]  = r_used[i] & (r_store[i] != wgm_pkg::STAR_BYTE) &
                        ((r_store[i] == wgm_pkg::QMARK_BYTE) || (r_store[i] == i_text));
        end
    end

    assign o_count      = r_count;
    assign o_count_next = n_count;
    assign o_start_next = n_start;
    assign o_full       = full;

endmodule

FILE: hdl/wgm_closure.sv
// Active-set advance for one text byte, with star closure done as a
// log-depth prefix over pattern positions. Depends on wgm_pkg.
`timescale 1ns / 1ps

module wgm_closure #(
    parameter int PATTERN_LEN = wgm_pkg::PATTERN_LEN_DEF
) (
    input  logic [PATTERN_LEN:0]   i_act,
    input  logic [PATTERN_LEN-1:0] i_star,
    input  logic [PATTERN_LEN-1:0] i_hit,
    output logic [PATTERN_LEN:0]   o_act
);

    localparam int LV = $clog2(PATTERN_LEN + 1);

    logic [PATTERN_LEN:0] g;
    logic [PATTERN_LEN:0] p;

    always_comb begin
        // Step: a star keeps its position, a matching byte moves on one
        g = '0;
        for (int i = 0; i < PATTERN_LEN; i++) begin
            if (i_act[i] & i_star[i]) begin
                g[i] = 1'b1;
            end
            if (i_act[i] & i_hit[i]) begin
                g[i+1] = 1'b1;
            end
        end
        // Position j inherits from j-1 when j-1 holds a star
        p = {i_star, 1'b0};
        // Prefix: descending index so lower entries still hold the last level
        for (int l = 0; l < LV; l++) begin
            for (int j = PATTERN_LEN; j >= (1 << l); j--) begin
                g[j] = g[j] | (p[j] & g[j - (1 << l)]);
                p[j] = p[j] & p[j - (1 << l)];
            end
        end
        o_act = g;
    end

endmodule

FILE: hdl/wildcard_glob_matcher.sv
// Top level of the wildcard glob matcher: input register, pattern store,
// active-set update and result register. Depends on wgm_pkg, wgm_pattern
// and wgm_closure.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_valid / o_stall) carries one word per item: a command
//   (clear pattern, append pattern byte, text byte), the byte and, for text,
//   a last flag. '*' matches any run of bytes, '?' exactly one byte.
//   Output channel (o_valid / i_stall) returns one result word per input
//   word: matched (text so far matches the whole pattern), text_end (word
//   closes a string) and overflow (append dropped, store full).
//   Path: an accepted word is held in the input register until the result
//   register is free or taken, and then its result loads there.
//   Throughput: one word per cycle while the output channel is not stalled;
//   the active-set update with star closure is a single combinational pass
//   between the two registers.
//   Reset: pattern empty, only position zero active, both registers empty.
//   Stall: while the result register is full and stalled, the input
//   register holds one further word; when both are full o_stall rises and
//   nothing is lost. Appends and clears restart any string in progress.

module wildcard_glob_matcher #(
    parameter int PATTERN_LEN = wgm_pkg::PATTERN_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_char_value,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_matched,
    output logic       o_text_end,
    output logic       o_overflow
);

    localparam int CW = $clog2(PATTERN_LEN + 1);

    logic                   r_s_valid;
    wgm_pkg::t_cmd          r_s_cmd;
    logic [7:0]             r_s_char;
    logic                   r_s_last;
    logic                   r_o_valid;
    logic                   r_o_matched;
    logic                   r_o_text_end;
    logic                   r_o_overflow;
    logic [PATTERN_LEN:0]   r_act;
    logic [PATTERN_LEN:0]   n_act;
    logic                   n_matched;
    logic                   n_text_end;
    logic                   n_overflow;
    logic                   accept_in;
    logic                   advance;
    wgm_pkg::t_pat_ctrl     pat_ctrl;
    logic [CW-1:0]          count;
    logic [CW-1:0]          count_next;
    logic [PATTERN_LEN:0]   start_next;
    logic                   full;
    logic [PATTERN_LEN-1:0] star;
    logic [PATTERN_LEN-1:0] hit;
    logic [PATTERN_LEN:0]   step_act;

    // Handshake: the stage moves on when the result register is free or taken
    assign advance   = r_s_valid & (~r_o_valid | ~i_stall);
    assign o_stall   = r_s_valid & r_o_valid & i_stall;
    assign accept_in = i_valid & ~o_stall;

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (accept_in) begin
            r_s_valid <= 1'b1;
        end else if (advance) begin
            r_s_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s_cmd  <= wgm_pkg::t_cmd'(i_cmd);
            r_s_char <= i_char_value;
            r_s_last <= i_last;
        end
    end

    // Drive pattern updates only when the word is consumed
    always_comb begin
        pat_ctrl.clear      = advance & (r_s_cmd == wgm_pkg::CMD_CLEAR);
        pat_ctrl.append     = advance & (r_s_cmd == wgm_pkg::CMD_APPEND);
        pat_ctrl.char_value = r_s_char;
    end

    wgm_pattern #(
        .PATTERN_LEN (PATTERN_LEN)
    ) u_pattern (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (pat_ctrl),
        .i_text       (r_s_char),
        .o_count      (count),
        .o_count_next (count_next),
        .o_start_next (start_next),
        .o_full       (full),
        .o_star       (star),
        .o_hit        (hit)
    );

    wgm_closure #(
        .PATTERN_LEN (PATTERN_LEN)
    ) u_closure (
        .i_act  (r_act),
        .i_star (star),
        .i_hit  (hit),
        .o_act  (step_act)
    );

    // Form the result and the next active set
    always_comb begin
        n_act      = r_act;
        n_matched  = r_act[count];
        n_text_end = 1'b0;
        n_overflow = 1'b0;
        case (r_s_cmd)
            wgm_pkg::CMD_CLEAR: begin
                n_act     = start_next;
                n_matched = start_next[count_next];
            end
            wgm_pkg::CMD_APPEND: begin
                n_act      = start_next;
                n_matched  = start_next[count_next];
                n_overflow = full;
            end
            wgm_pkg::CMD_TEXT: begin
                n_matched  = step_act[count];
                n_text_end = r_s_last;
                // restart after a closing byte
                n_act      = r_s_last ? start_next : step_act;
            end
            default: begin
                n_act = r_act;
            end
        endcase
    end

    // Advance the active set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= {{PATTERN_LEN{1'b0}}, 1'b1};
        end else if (advance) begin
            r_act <= n_act;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= 1'b1;
        end else if (~i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_matched  <= n_matched;
            r_o_text_end <= n_text_end;
            r_o_overflow <= n_overflow;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_matched  = r_o_matched;
    assign o_text_end = r_o_text_end;
    assign o_overflow = r_o_overflow;

endmodule

FILE: hdl/wgm_checker.sv
// Port-level checks for the wildcard glob matcher, bound to the top level.
// Depends on wildcard_glob_matcher.
`timescale 1ns / 1ps

module wgm_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic o_stall,
    input  logic o_valid,
    input  logic i_stall,
    input  logic o_matched,
    input  logic o_text_end,
    input  logic o_overflow
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word shown straight after reset");

    // Input stalls only when the result register is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // A word never both closes a string and reports a dropped append
    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_text_end && o_overflow))
        else $error("text_end and overflow raised together");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_matched) && $stable(o_text_end) &&
             $stable(o_overflow)))
        else $error("stalled result word changed");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_matched  (o_matched),
    .o_text_end (o_text_end),
    .o_overflow (o_overflow)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the wildcard glob matcher: directed and random
// pattern and text words, random idling on both channels. Depends on wgm_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam int PAT_LEN     = wgm_pkg::PATTERN_LEN_DEF;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic matched;
        logic text_end;
        logic overflow;
    } t_verdict;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [1:0] i_cmd        = wgm_pkg::CMD_NONE;
    logic [7:0] i_char_value = 8'd0;
    logic       i_last       = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_matched;
    logic       o_text_end;
    logic       o_overflow;

    // Predicted pattern, length and reachable positions
    logic [7:0]       pat_bytes [PAT_LEN];
    int               pat_len = 0;
    logic [PAT_LEN:0] reach   = {{PAT_LEN{1'b0}}, 1'b1};

    t_verdict pending_verdicts[$];
    int       sent_words  = 0;
    int       seen_words  = 0;
    int       fail_count  = 0;
    int       cycle_count = 0;
    bit       idle_on     = 1'b1;

    wildcard_glob_matcher u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_char_value (i_char_value),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_matched    (o_matched),
        .o_text_end   (o_text_end),
        .o_overflow   (o_overflow)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Extend the reachable set across every active star
    function automatic logic [PAT_LEN:0] star_closure(input logic [PAT_LEN:0] s);
        logic [PAT_LEN:0] r;
        r = s;
        for (int i = 0; i < pat_len; i++) begin
            if (r[i] && pat_bytes[i] == wgm_pkg::STAR_BYTE) r[i+1] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [PAT_LEN:0] restart_reach();
        return star_closure({{PAT_LEN{1'b0}}, 1'b1});
    endfunction

    // Advance the predicted state by one word and form its verdict
    function automatic t_verdict glob_step(input wgm_pkg::t_cmd cmd, input logic [7:0] ch,
                                           input logic last);
        t_verdict         v;
        logic [PAT_LEN:0] nxt;
        v = '0;
        case (cmd)
            wgm_pkg::CMD_CLEAR: begin
                pat_len = 0;
                reach   = restart_reach();
            end
            wgm_pkg::CMD_APPEND: begin
                if (pat_len < PAT_LEN) begin
                    pat_bytes[pat_len] = ch;
                    pat_len++;
                end else begin
                    v.overflow = 1'b1;
                end
                reach = restart_reach();
            end
            wgm_pkg::CMD_TEXT: begin
                nxt = '0;
                for (int i = 0; i < pat_len; i++) begin
                    if (reach[i]) begin
                        if (pat_bytes[i] == wgm_pkg::STAR_BYTE) nxt[i] = 1'b1;
                        else if (pat_bytes[i] == wgm_pkg::QMARK_BYTE || pat_bytes[i] == ch)
                            nxt[i+1] = 1'b1;
                    end
                end
                reach = star_closure(nxt);
            end
            default: ;
        endcase
        v.matched = reach[pat_len];
        if (cmd == wgm_pkg::CMD_TEXT && last) begin
            v.text_end = 1'b1;
            reach      = restart_reach();
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("word %0d: %s got %0d, want %0d", seen_words, what, got, want);
        fail_count++;
    endtask

    // Send one word, with an occasional idle burst before it
    task automatic send_word(input wgm_pkg::t_cmd cmd, input logic [7:0] ch,
                             input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_char_value <= ch;
        i_last       <= last;
        pending_verdicts.push_back(glob_step(cmd, ch, last));
        sent_words++;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Hold the sender until every verdict is back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_glob_byte();
        case ($urandom_range(0, 9))
            0, 1:    return wgm_pkg::STAR_BYTE;
            2:       return wgm_pkg::QMARK_BYTE;
            3:       return 8'($urandom_range(0, 255));
            4:       return 8'h00;
            default: return 8'("a" + $urandom_range(0, 2));
        endcase
    endfunction

    function automatic logic [7:0] rand_text_byte();
        case ($urandom_range(0, 7))
            0:       return 8'($urandom_range(0, 255));
            1:       return $urandom_range(0, 1) ? wgm_pkg::STAR_BYTE : wgm_pkg::QMARK_BYTE;
            default: return 8'("a" + $urandom_range(0, 2));
        endcase
    endfunction

    task automatic send_glob(input int len);
        send_word(wgm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        repeat (len)
            send_word(wgm_pkg::CMD_APPEND, rand_glob_byte(), 1'($urandom_range(0, 1)));
    endtask

    // Send a string, mostly one that fits the current pattern, with some damage
    task automatic send_string(input int max_len, input bit fitting, input bit closed);
        logic [7:0] text_q[$];
        int         n;
        if (fitting) begin
            for (int i = 0; i < pat_len; i++) begin
                if (pat_bytes[i] == wgm_pkg::STAR_BYTE) begin
                    n = $urandom_range(0, 3);
                    repeat (n) text_q.push_back(rand_text_byte());
                end else if (pat_bytes[i] == wgm_pkg::QMARK_BYTE) begin
                    text_q.push_back(rand_text_byte());
                end else begin
                    text_q.push_back(pat_bytes[i]);
                end
            end
            foreach (text_q[k]) if ($urandom_range(0, 11) == 0) text_q[k] = rand_text_byte();
            if ($urandom_range(0, 7) == 0) text_q.push_back(rand_text_byte());
            if ($urandom_range(0, 7) == 0 && text_q.size() > 1) void'(text_q.pop_back());
        end else begin
            n = $urandom_range(1, max_len);
            repeat (n) text_q.push_back(rand_text_byte());
        end
        if (text_q.size() == 0) text_q.push_back(rand_text_byte());
        foreach (text_q[k])
            send_word(wgm_pkg::CMD_TEXT, text_q[k], closed && (k == text_q.size() - 1));
    endtask

    // Extremes and each special case, by hand
    task automatic test_directed();
        send_word(wgm_pkg::CMD_NONE, 8'h00, 1'b0);
        send_word(wgm_pkg::CMD_TEXT, "a", 1'b1);
        send_word(wgm_pkg::CMD_CLEAR, 8'hFF, 1'b1);
        send_word(wgm_pkg::CMD_APPEND, "a", 1'b0);
        send_word(wgm_pkg::CMD_APPEND, wgm_pkg::QMARK_BYTE, 1'b0);
        send_word(wgm_pkg::CMD_APPEND, "c", 1'b0);
        send_word(wgm_pkg::CMD_TEXT, "a", 1'b0);
        send_word(wgm_pkg::CMD_TEXT, "x", 1'b0);
        send_word(wgm_pkg::CMD_TEXT, "c", 1'b1);
        send_word(wgm_pkg::CMD_TEXT, "a", 1'b0);
        send_word(wgm_pkg::CMD_TEXT, "b", 1'b1);
        send_word(wgm_pkg::CMD_APPEND, wgm_pkg::STAR_BYTE, 1'b1);
        send_word(wgm_pkg::CMD_TEXT, "a", 1'b0);
        send_word(wgm_pkg::CMD_TEXT, wgm_pkg::QMARK_BYTE, 1'b0);
        send_word(wgm_pkg::CMD_TEXT, "c", 1'b0);
        send_word(wgm_pkg::CMD_TEXT, "d", 1'b1);
        send_word(wgm_pkg::CMD_CLEAR, 8'h00, 1'b0);
        send_word(wgm_pkg::CMD_APPEND, wgm_pkg::STAR_BYTE, 1'b0);
        send_word(wgm_pkg::CMD_TEXT, 8'hFF, 1'b1);
        send_word(wgm_pkg::CMD_CLEAR, 8'h00, 1'b0);
        send_word(wgm_pkg::CMD_APPEND, 8'h00, 1'b0);
        send_word(wgm_pkg::CMD_TEXT, 8'h00, 1'b1);
        send_word(wgm_pkg::CMD_NONE, 8'hFF, 1'b1);
        send_word(wgm_pkg::CMD_APPEND, wgm_pkg::QMARK_BYTE, 1'b0);
        send_word(wgm_pkg::CMD_TEXT, 8'h00, 1'b0);
        send_word(wgm_pkg::CMD_TEXT, wgm_pkg::STAR_BYTE, 1'b1);
    endtask

    // Short random globs with strings; some noise and broken strings
    task automatic test_random_globs(input int budget);
        int start;
        int strings;
        start = sent_words;
        while (sent_words - start < budget) begin
            case ($urandom_range(0, 9))
                0: send_word(wgm_pkg::t_cmd'($urandom_range(0, 3)),
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                1: begin
                    send_string(6, 1'($urandom_range(0, 1)), 1'b0);
                    send_word($urandom_range(0, 1) ? wgm_pkg::CMD_APPEND : wgm_pkg::CMD_CLEAR,
                              rand_glob_byte(), 1'($urandom_range(0, 1)));
                    send_string(6, 1'b1, 1'b1);
                end
                default: begin
                    send_glob($urandom_range(0, 8));
                    strings = $urandom_range(1, 4);
                    repeat (strings) send_string(10, $urandom_range(0, 3) != 0, 1'b1);
                end
            endcase
        end
    endtask

    // Full store, appends beyond capacity, long strings
    task automatic test_capacity();
        int extra;
        int strings;
        repeat (6) begin
            send_glob($urandom_range(PAT_LEN - 4, PAT_LEN));
            extra = $urandom_range(0, 3);
            repeat (extra)
                send_word(wgm_pkg::CMD_APPEND, rand_glob_byte(), 1'($urandom_range(0, 1)));
            strings = $urandom_range(1, 3);
            repeat (strings) send_string(40, $urandom_range(0, 3) != 0, 1'b1);
        end
    endtask

    // Stimulus sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        drain_results();
        test_random_globs(300);
        drain_results();
        test_capacity();
        drain_results();
        idle_on = 1'b0;
        test_random_globs(170);
        drain_results();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Stall the result channel in random bursts
    always @(posedge i_clk) begin
        static int stall_left = 0;
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Compare each accepted result word with the oldest verdict
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result, matched", int'(o_matched), 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_matched !== want.matched)
                    report_mismatch("matched", int'(o_matched), int'(want.matched));
                if (o_text_end !== want.text_end)
                    report_mismatch("text_end", int'(o_text_end), int'(want.text_end));
                if (o_overflow !== want.overflow)
                    report_mismatch("overflow", int'(o_overflow), int'(want.overflow));
            end
            seen_words++;
        end
    end

    // Drop out if the run hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

FILE: sim.f
hdl/wgm_pkg.sv
hdl/wgm_pattern.sv
hdl/wgm_closure.sv
hdl/wildcard_glob_matcher.sv
hdl/wgm_checker.sv
tb/sv/testbench.sv
